/* sv/sitda_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the signed integer to decimal ASCII block.
// Used by sitda_cell and signed_int_to_decimal_ascii; no dependencies.
package sitda_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int NUM_CELLS   = 20;   // enough BCD digits for any 64-bit magnitude
   localparam int DIGIT_WIDTH = 4;
   localparam int CHAR_WIDTH  = 8;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'd57;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'd45;

   // Per-cycle command broadcast to every digit cell
   typedef struct packed {
      logic clear;    // zero the digit
      logic dabble;   // add-3 correction, then shift one bit in from below
      logic move;     // take the lower neighbor's digit (drain toward the top)
   } cell_ctrl_type;

endpackage

/* sv/signed_int_to_decimal_ascii.sv */
`timescale 1ns / 1ps
// Signed 64-bit integer to decimal ASCII text, top level.
// Depends on sitda_pkg and a chain of sitda_cell digit cells.
//
// One request transaction carries a signed 64-bit value; the block answers with
// a run of 1 to 20 response transactions, one ASCII character each, most
// significant first, tlast on the final one. Negative values get a leading '-'
// (the most negative value converts correctly), zero gives "0", and leading
// zeros never appear. One value is handled at a time: after acceptance the
// magnitude is shifted bit-serially into a chain of 20 BCD digit cells over
// all 64 of its bits (double dabble), then the chain drains toward the top
// cell one digit per cycle, a leading zero being dropped at once and each
// character waiting until the output register is free. The next value is
// accepted as soon as the final character sits in the output register.
module signed_int_to_decimal_ascii (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [sitda_pkg::VALUE_WIDTH-1:0]     req_tdata,   // [63:0] value (signed)
   // response channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [sitda_pkg::CHAR_WIDTH-1:0]      rsp_tdata,   // [7:0] character
   output logic                                  rsp_tlast    // last character of the number
);
   import sitda_pkg::*;

   localparam int CONV_CNT_W = $clog2(VALUE_WIDTH);
   localparam int REM_W      = $clog2(NUM_CELLS + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_SIGN = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   logic [VALUE_WIDTH-1:0]   mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic [CONV_CNT_W-1:0]    conv_cnt_ff, conv_cnt_in;
   logic [REM_W-1:0]         remain_ff, remain_in;    // digits left in the chain
   logic                     started_ff, started_in;  // first nonzero digit seen
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]    rsp_data_ff, rsp_data_in;
   logic                     rsp_last_ff, rsp_last_in;

   cell_ctrl_type            ctrl;
   logic                     carry [0:NUM_CELLS];
   logic [DIGIT_WIDTH-1:0]   digit [0:NUM_CELLS];
   logic [DIGIT_WIDTH-1:0]   top_digit;
   logic                     out_free;
   logic                     req_take;

   // ---------------------------------------------------------------
   // Digit cell chain: cell 0 is the least significant decade. During
   // conversion bits ripple upward through the carries; during draining
   // digits move up one cell per step and leave from the top cell.
   // ---------------------------------------------------------------
   assign carry[0] = mag_ff[VALUE_WIDTH-1];
   assign digit[0] = '0;

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      sitda_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .bit_in    (carry[i]),
         .digit_in  (digit[i]),
         .bit_out   (carry[i+1]),
         .digit_out (digit[i+1])
      );
   end

   // top carry is always zero: the magnitude never exceeds 20 decades
   assign top_digit = digit[NUM_CELLS];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      conv_cnt_in  = conv_cnt_ff;
      remain_in    = remain_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      ctrl         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               neg_in      = req_tdata[VALUE_WIDTH-1];
               // two's complement magnitude; the most negative value maps to 2^63
               mag_in      = req_tdata[VALUE_WIDTH-1] ? (~req_tdata + 1'b1) : req_tdata;
               conv_cnt_in = '0;
               ctrl.clear  = 1'b1;
               state_in    = ST_CONV;
            end
         end
         ST_CONV: begin
            ctrl.dabble = 1'b1;
            mag_in      = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            conv_cnt_in = conv_cnt_ff + 1'b1;
            if (conv_cnt_ff == CONV_CNT_W'(VALUE_WIDTH - 1)) begin
               remain_in  = REM_W'(NUM_CELLS);
               started_in = 1'b0;
               state_in   = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!started_ff && top_digit == '0 && remain_ff != REM_W'(1)) begin
               // leading zero: drop it without using the output slot
               ctrl.move = 1'b1;
               remain_in = remain_ff - 1'b1;
            end else if (out_free) begin
               ctrl.move    = 1'b1;
               remain_in    = remain_ff - 1'b1;
               started_in   = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = CHAR_ZERO + CHAR_WIDTH'(top_digit);
               rsp_last_in  = (remain_ff == REM_W'(1));
               if (remain_ff == REM_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         conv_cnt_ff  <= '0;
         remain_ff    <= '0;
         started_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         conv_cnt_ff  <= conv_cnt_in;
         remain_ff    <= remain_in;
         started_ff   <= started_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // only '-' or a decimal digit ever leaves the block
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata == CHAR_MINUS ||
                      (rsp_tdata >= CHAR_ZERO && rsp_tdata <= CHAR_NINE)))
      else $error("response character out of range");

   // a new value is taken only once its run has ended at the output
   a_run_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> !req_tready)
      else $error("request accepted while a run is still open");

   // conversion lasts exactly one pass over the value's bits
   a_conv_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV && conv_cnt_ff == CONV_CNT_W'(VALUE_WIDTH - 1))
      |=> (state_ff != ST_CONV))
      else $error("conversion did not end after the last bit");

   // '-' is never the final character
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata == CHAR_MINUS) |-> !rsp_tlast)
      else $error("minus sign marked as last character");

   // nothing carries out of the top decade while shifting
   a_top_carry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV) |-> !carry[NUM_CELLS])
      else $error("carry out of the top digit cell");

endmodule

/* sv/sitda_cell.sv */
`timescale 1ns / 1ps
// One BCD digit cell of the double-dabble chain.
// Depends on sitda_pkg for the command struct and digit width.
module sitda_cell (
   input  logic                                clock,
   input  sitda_pkg::cell_ctrl_type            ctrl,
   input  logic                                bit_in,
   input  logic [sitda_pkg::DIGIT_WIDTH-1:0]   digit_in,
   output logic                                bit_out,
   output logic [sitda_pkg::DIGIT_WIDTH-1:0]   digit_out
);
   import sitda_pkg::*;

   logic [DIGIT_WIDTH-1:0] digit_ff;
   logic [DIGIT_WIDTH-1:0] digit_in_next;
   logic [DIGIT_WIDTH-1:0] adj;

   // add 3 when >= 5 so the following shift carries correctly into the next decade
   assign adj = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;

   always_comb begin
      digit_in_next = digit_ff;
      if (ctrl.clear) begin
         digit_in_next = '0;
      end else if (ctrl.dabble) begin
         digit_in_next = {adj[DIGIT_WIDTH-2:0], bit_in};
      end else if (ctrl.move) begin
         digit_in_next = digit_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_next;
   end

   assign bit_out   = adj[DIGIT_WIDTH-1];
   assign digit_out = digit_ff;

endmodule

/* dv/signed_int_to_decimal_ascii_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for signed_int_to_decimal_ascii: watches both streams, predicts the text.
// Depends on sitda_pkg for widths and character codes.
module signed_int_to_decimal_ascii_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [sitda_pkg::VALUE_WIDTH-1:0]  req_tdata,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [sitda_pkg::CHAR_WIDTH-1:0]   rsp_tdata,
   input  logic                               rsp_tlast,
   output int                                 error_count,
   output int                                 chars_outstanding
);

   import sitda_pkg::*;

   localparam logic [VALUE_WIDTH-1:0] DECIMAL_BASE = 64'd10;

   typedef struct {
      logic [CHAR_WIDTH-1:0] code;
      logic                  last;
   } text_char_type;

   text_char_type expected_text[$];

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   // Queue the characters of one value, sign first, most significant digit next.
   function automatic void expand_decimal_text(input logic [VALUE_WIDTH-1:0] value);
      logic [VALUE_WIDTH-1:0] magnitude;
      logic [CHAR_WIDTH-1:0]  digit_chars[NUM_CELLS];
      int                     ndigits;
      text_char_type          entry;
      magnitude = value[VALUE_WIDTH-1] ? (~value + 64'd1) : value;
      ndigits   = 0;
      if (magnitude == '0) begin
         digit_chars[0] = CHAR_ZERO;
         ndigits        = 1;
      end else begin
         while (magnitude != '0) begin
            digit_chars[ndigits] = CHAR_ZERO + CHAR_WIDTH'(magnitude % DECIMAL_BASE);
            magnitude            = magnitude / DECIMAL_BASE;
            ndigits++;
         end
      end
      if (value[VALUE_WIDTH-1]) begin
         entry.code = CHAR_MINUS;
         entry.last = 1'b0;
         expected_text.push_back(entry);
      end
      for (int k = ndigits - 1; k >= 0; k--) begin
         entry.code = digit_chars[k];
         entry.last = (k == 0);
         expected_text.push_back(entry);
      end
   endfunction

   always @(posedge clock) begin
      text_char_type want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expand_decimal_text(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_text.size() == 0) begin
               report_mismatch($sformatf("unexpected character 0x%02h last %b",
                                         rsp_tdata, rsp_tlast));
            end else begin
               want = expected_text.pop_front();
               if (rsp_tdata !== want.code)
                  report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                            rsp_tdata, want.code));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("tlast %b on character 0x%02h, expected %b",
                                            rsp_tlast, want.code, want.last));
            end
         end
      end
      // registered so the stimulus side reads a stable value at the edge
      chars_outstanding <= expected_text.size();
   end

endmodule

/* dv/signed_int_to_decimal_ascii_tb.sv */
`timescale 1ns / 1ps
// Testbench top for signed_int_to_decimal_ascii: clock, reset, stimulus, verdict.
// Depends on sitda_pkg, the block and signed_int_to_decimal_ascii_checker.
module signed_int_to_decimal_ascii_tb;

   import sitda_pkg::*;

   localparam int RANDOM_ITEMS = 295;
   localparam int QUIET_ITEMS  = 40;      // final items run without idling on either side
   localparam int HOLD_CYCLES  = 400;     // long sink hold-off, well past one conversion
   localparam int TAIL_CYCLES  = 120;     // settle time after the last expected character
   localparam int CYCLE_LIMIT  = 400000;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [VALUE_WIDTH-1:0] req_tdata  = '0;      // [63:0] value (signed)
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [CHAR_WIDTH-1:0]  rsp_tdata;            // [7:0] character
   logic                   rsp_tlast;

   int error_count;
   int chars_outstanding;
   int cycle_count  = 0;
   bit random_phase = 1'b0;   // set once the directed part has fully drained
   bit quiet_tail   = 1'b0;   // no idling on either side from here on

   always #2 clock = ~clock;

   signed_int_to_decimal_ascii u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   signed_int_to_decimal_ascii_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tlast         (rsp_tlast),
      .error_count       (error_count),
      .chars_outstanding (chars_outstanding)
   );

   // Runaway guard: any hang in either handshake ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("signed_int_to_decimal_ascii regression: fail");
         $finish;
      end
   end

   function automatic logic [VALUE_WIDTH-1:0] pow10(input int exponent);
      logic [VALUE_WIDTH-1:0] acc;
      acc = 64'd1;
      repeat (exponent) acc = acc * 64'd10;
      return acc;
   endfunction

   // Random value mix: full 64-bit patterns exercise every bit, the rest aim at
   // digit-count boundaries (9..9 / 10..0), short texts and random lengths, with either sign.
   function automatic logic [VALUE_WIDTH-1:0] next_test_value();
      logic [VALUE_WIDTH-1:0] v;
      int                     kind;
      kind = $urandom_range(0, 3);
      case (kind)
         0: begin
            v = {$urandom(), $urandom()};
         end
         1: begin
            v = VALUE_WIDTH'($urandom_range(0, 1000));
         end
         2: begin
            v = pow10($urandom_range(1, 18)) + VALUE_WIDTH'($urandom_range(0, 2)) - 64'd1;
         end
         default: begin
            v = {$urandom(), $urandom()} % pow10($urandom_range(1, 18));
         end
      endcase
      if (kind != 0 && $urandom_range(0, 1) == 1)
         v = ~v + 64'd1;
      return v;
   endfunction

   // Offer one value and hold it until the block takes it. An optional idle
   // burst in front puts gaps on every phase of the conversion.
   task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Wait until every queued character has come back; chars_outstanding is
   // registered, so the first edge lets the last transaction's text land.
   task automatic drain_text();
      @(posedge clock);
      while (chars_outstanding != 0) @(posedge clock);
   endtask

   // Response sink: one long hold-off early in the random part so the block's
   // output fills and it stops taking requests, then random stall bursts
   // mixed with ready stretches, and a steady ready in the quiet tail.
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (random_phase && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   initial begin
      logic [VALUE_WIDTH-1:0] directed_values[$];
      // zero, unit values, sign boundaries, most negative (20 characters),
      // largest positive, and digit-count boundaries up to 19 digits
      directed_values = '{
         64'd0, 64'd1, -64'sd1, 64'd9, -64'sd9, 64'd10, -64'sd10,
         64'd99, 64'd100, -64'sd100,
         64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFE,
         64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
         64'd999999999999999999, 64'd1000000000000000000, -64'sd1000000000000000000,
         64'd123456789, -64'sd12345678901234567, 64'd4294967295, 64'd4294967296,
         64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF, 64'h5555_5555_5555_5555,
         64'hAAAA_AAAA_AAAA_AAAA
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_values[i])
         send_value(directed_values[i]);

      // Sender pause: stay idle until the block has returned every character.
      req_tvalid <= 1'b0;
      drain_text();
      random_phase = 1'b1;

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - QUIET_ITEMS)
            quiet_tail = 1'b1;
         send_value(next_test_value());
      end
      req_tvalid <= 1'b0;

      drain_text();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("signed_int_to_decimal_ascii regression: pass");
      end else begin
         $display("signed_int_to_decimal_ascii regression: fail");
      end
      $finish;
   end

endmodule
